[sv/sfir_pkg.sv]
// Shared types and constants for the stereo FIR filter core.
package sfir_pkg;

    localparam int OP_W        = 2;
    localparam int TAP_COUNT_W = 13;
    localparam int TAP_INDEX_W = 12;
    localparam int CFG_IDX_W   = 1;

    typedef enum logic [OP_W-1:0] {
        OP_FRAME = 2'd0,
        OP_COEF  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 1'd1;

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 13'd4096;

    // Controller to datapath commands.
    typedef struct packed {
        logic coef_wr;
        logic load_item;
        logic hist_wr;
        logic clr_run;
        logic mac_issue;
        logic round;
        logic sat;
        logic emit;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic clr_last;
        logic issue_last;
        logic pipe_idle;
        logic out_free;
        logic filter_en;
    } sts_t;

endpackage

[sv/sfir_datapath.sv]
// Datapath: configuration, coefficient and history memories, MAC pipeline, output register.
module sfir_datapath #(
    parameter int MAX_TAPS    = 4096,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sfir_pkg::cmd_t                         cmd,
    output sfir_pkg::sts_t                         sts,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sfir_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sfir_pkg::TAP_COUNT_W-1:0]       cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]          left_in,
    input  logic signed [SAMPLE_BITS-1:0]          right_in,
    input  logic [sfir_pkg::TAP_INDEX_W-1:0]       tap_index,
    input  logic signed [COEF_BITS-1:0]            tap_value,
    input  logic                                   frame_last,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [SAMPLE_BITS-1:0]          left_out,
    output logic signed [SAMPLE_BITS-1:0]          right_out,
    output logic                                   clipped,
    output logic                                   last_out
);
    import sfir_pkg::*;

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int NW    = $clog2(MAX_TAPS + 1);
    localparam int CW    = (NW > TAP_COUNT_W) ? NW : TAP_COUNT_W;
    localparam int IW    = (AW + 1 > TAP_INDEX_W) ? AW + 1 : TAP_INDEX_W;
    localparam int PW    = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W = SAMPLE_BITS + COEF_BITS + AW + 1;
    localparam int SH    = COEF_BITS - 3;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (SH - 1);

    // Memories
    logic signed [COEF_BITS-1:0]   coef_mem  [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] lhist_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] rhist_mem [MAX_TAPS];

    logic signed [COEF_BITS-1:0]   coef_q_reg;
    logic signed [SAMPLE_BITS-1:0] hl_q_reg;
    logic signed [SAMPLE_BITS-1:0] hr_q_reg;

    // Control registers
    logic [TAP_COUNT_W-1:0] tap_count_reg, tap_count_next;
    logic                   en_reg, en_next;
    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [NW-1:0]          k_reg, k_next;
    logic [NW-1:0]          n_reg, n_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic                   prod_vld_reg, prod_vld_next;
    logic                   out_valid_reg, out_valid_next;

    // Payload registers
    logic signed [PW-1:0]          prod_l_reg, prod_l_next;
    logic signed [PW-1:0]          prod_r_reg, prod_r_next;
    logic signed [ACC_W-1:0]       acc_l_reg, acc_l_next;
    logic signed [ACC_W-1:0]       acc_r_reg, acc_r_next;
    logic signed [ACC_W-1:0]       rnd_l_reg, rnd_l_next;
    logic signed [ACC_W-1:0]       rnd_r_reg, rnd_r_next;
    logic signed [SAMPLE_BITS-1:0] res_l_reg, res_l_next;
    logic signed [SAMPLE_BITS-1:0] res_r_reg, res_r_next;
    logic                          res_clip_reg, res_clip_next;
    logic                          res_last_reg, res_last_next;
    logic signed [SAMPLE_BITS-1:0] out_l_reg, out_l_next;
    logic signed [SAMPLE_BITS-1:0] out_r_reg, out_r_next;
    logic                          out_clip_reg, out_clip_next;
    logic                          out_last_reg, out_last_next;

    // Combinational helpers
    logic [CW-1:0]          tc_ext;
    logic [NW-1:0]          n_sat;
    logic [NW-1:0]          n_sat_m1;
    logic [NW-1:0]          n_reg_m1;
    logic [AW-1:0]          pos_c;
    logic [IW-1:0]          ti_ext;
    logic                   coef_we;
    logic [NW-1:0]          idx_inc;
    logic [AW-1:0]          idx_wrap;
    logic                   hist_we;
    logic [AW-1:0]          hist_waddr;
    logic signed [SAMPLE_BITS-1:0] hl_wdata;
    logic signed [SAMPLE_BITS-1:0] hr_wdata;
    logic [SAMPLE_BITS:0]   sat_l;
    logic [SAMPLE_BITS:0]   sat_r;

    // Round by shift, then clamp to the sample range; MSB of the result flags clamping.
    function automatic logic [SAMPLE_BITS:0] round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0]            sh;
        logic [ACC_W-SAMPLE_BITS:0]         top;
        logic [SAMPLE_BITS:0]               r;
        sh  = v >>> SH;
        top = sh[ACC_W-1:SAMPLE_BITS-1];
        if ((&top) || !(|top)) begin
            r = {1'b0, sh[SAMPLE_BITS-1:0]};
        end
        else if (sh[ACC_W-1]) begin
            r = {1'b1, 1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else begin
            r = {1'b1, 1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    always_comb
    begin
        tc_ext = CW'(tap_count_reg);
        if (tc_ext < CW'(4)) begin
            n_sat = NW'(4);
        end
        else if (tc_ext > CW'(MAX_TAPS)) begin
            n_sat = NW'(MAX_TAPS);
        end
        else begin
            n_sat = tc_ext[NW-1:0];
        end
        n_sat_m1 = n_sat - NW'(1);
        n_reg_m1 = n_reg - NW'(1);
        // Pull the position inside the ring after tap_count was lowered
        pos_c = (NW'(pos_reg) >= n_sat) ? n_sat_m1[AW-1:0] : pos_reg;

        ti_ext  = IW'(tap_index);
        coef_we = cmd.coef_wr && (ti_ext < IW'(MAX_TAPS));

        idx_inc  = NW'(idx_reg) + NW'(1);
        idx_wrap = (idx_inc == n_reg) ? '0 : idx_inc[AW-1:0];

        hist_we    = cmd.clr_run || cmd.hist_wr;
        hist_waddr = cmd.clr_run ? clr_cnt_reg : pos_c;
        hl_wdata   = cmd.clr_run ? '0 : left_in;
        hr_wdata   = cmd.clr_run ? '0 : right_in;

        sat_l = round_sat(rnd_l_reg);
        sat_r = round_sat(rnd_r_reg);
    end

    always_ff @(posedge clk)
    begin
        if (coef_we) begin
            coef_mem[ti_ext[AW-1:0]] <= tap_value;
        end
        coef_q_reg <= coef_mem[k_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we) begin
            lhist_mem[hist_waddr] <= hl_wdata;
            rhist_mem[hist_waddr] <= hr_wdata;
        end
        hl_q_reg <= lhist_mem[idx_reg];
        hr_q_reg <= rhist_mem[idx_reg];
    end

    always_comb
    begin
        tap_count_next = tap_count_reg;
        en_next        = en_reg;
        clr_cnt_next   = clr_cnt_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        rd_vld_next    = cmd.mac_issue;
        prod_vld_next  = rd_vld_reg;
        out_valid_next = out_valid_reg;
        prod_l_next    = prod_l_reg;
        prod_r_next    = prod_r_reg;
        acc_l_next     = acc_l_reg;
        acc_r_next     = acc_r_reg;
        rnd_l_next     = rnd_l_reg;
        rnd_r_next     = rnd_r_reg;
        res_l_next     = res_l_reg;
        res_r_next     = res_r_reg;
        res_clip_next  = res_clip_reg;
        res_last_next  = res_last_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;
        out_clip_next  = out_clip_reg;
        out_last_next  = out_last_reg;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_TAP_COUNT:     tap_count_next = cfg_data;
                CFG_FILTER_ENABLE: en_next = cfg_data[0];
                default:           ;
            endcase
        end

        if (cmd.clr_run) begin
            clr_cnt_next = (clr_cnt_reg == AW'(MAX_TAPS - 1)) ? '0 : clr_cnt_reg + AW'(1);
            pos_next     = '0;
        end

        // Pass-through result; overwritten later when the filter runs
        if (cmd.load_item) begin
            res_l_next    = left_in;
            res_r_next    = right_in;
            res_clip_next = 1'b0;
            res_last_next = frame_last;
        end

        if (cmd.hist_wr) begin
            n_next     = n_sat;
            pos_next   = pos_c;
            idx_next   = pos_c;
            k_next     = '0;
            acc_l_next = '0;
            acc_r_next = '0;
        end

        if (cmd.mac_issue) begin
            k_next   = k_reg + NW'(1);
            idx_next = idx_wrap;
        end

        if (rd_vld_reg) begin
            prod_l_next = coef_q_reg * hl_q_reg;
            prod_r_next = coef_q_reg * hr_q_reg;
        end

        if (prod_vld_reg) begin
            acc_l_next = acc_l_reg + ACC_W'(prod_l_reg);
            acc_r_next = acc_r_reg + ACC_W'(prod_r_reg);
        end

        if (cmd.round) begin
            rnd_l_next = acc_l_reg + HALF;
            rnd_r_next = acc_r_reg + HALF;
        end

        if (cmd.sat) begin
            res_l_next    = sat_l[SAMPLE_BITS-1:0];
            res_r_next    = sat_r[SAMPLE_BITS-1:0];
            res_clip_next = sat_l[SAMPLE_BITS] || sat_r[SAMPLE_BITS];
            // Step the ring position down and wrap
            pos_next      = (pos_reg == '0) ? n_reg_m1[AW-1:0] : pos_reg - AW'(1);
        end

        if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_l_next     = res_l_reg;
            out_r_next     = res_r_reg;
            out_clip_next  = res_clip_reg;
            out_last_next  = res_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tap_count_reg <= TAP_COUNT_RST;
            en_reg        <= 1'b0;
            clr_cnt_reg   <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            k_reg         <= '0;
            n_reg         <= NW'(4);
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            tap_count_reg <= tap_count_next;
            en_reg        <= en_next;
            clr_cnt_reg   <= clr_cnt_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            rd_vld_reg    <= rd_vld_next;
            prod_vld_reg  <= prod_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_l_reg   <= prod_l_next;
        prod_r_reg   <= prod_r_next;
        acc_l_reg    <= acc_l_next;
        acc_r_reg    <= acc_r_next;
        rnd_l_reg    <= rnd_l_next;
        rnd_r_reg    <= rnd_r_next;
        res_l_reg    <= res_l_next;
        res_r_reg    <= res_r_next;
        res_clip_reg <= res_clip_next;
        res_last_reg <= res_last_next;
        out_l_reg    <= out_l_next;
        out_r_reg    <= out_r_next;
        out_clip_reg <= out_clip_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        sts.clr_last   = (clr_cnt_reg == AW'(MAX_TAPS - 1));
        sts.issue_last = (k_reg == n_reg_m1);
        sts.pipe_idle  = !rd_vld_reg && !prod_vld_reg;
        sts.out_free   = !out_valid_reg || !out_stall;
        sts.filter_en  = en_reg;
    end

    assign out_valid = out_valid_reg;
    assign left_out  = out_l_reg;
    assign right_out = out_r_reg;
    assign clipped   = out_clip_reg;
    assign last_out  = out_last_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over an unsent request");

    a_issue_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mac_issue |-> (k_reg < n_reg) && (NW'(idx_reg) < n_reg))
        else $error("tap read outside the ring");

    a_write_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hist_wr |-> (NW'(pos_c) < n_sat))
        else $error("history write outside the ring");

    a_round_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round |-> (!rd_vld_reg && !prod_vld_reg))
        else $error("rounding before the MAC pipeline drained");

endmodule

[sv/sfir_ctrl.sv]
// Controller: state machine sequencing clear sweeps, MAC passes and result hand-off.
module sfir_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [sfir_pkg::OP_W-1:0]   op,
    output logic                        in_stall,
    output sfir_pkg::cmd_t              cmd,
    input  sfir_pkg::sts_t              sts
);
    import sfir_pkg::*;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_RUN   = 7'b0000100,
        ST_DRAIN = 7'b0001000,
        ST_ROUND = 7'b0010000,
        ST_SAT   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = (state_reg != ST_IDLE);
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_run = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid) begin
                    case (op)
                        OP_FRAME:
                        begin
                            cmd.load_item = 1'b1;
                            if (sts.filter_en) begin
                                cmd.hist_wr = 1'b1;
                                state_next  = ST_RUN;
                            end
                            else begin
                                state_next = ST_EMIT;
                            end
                        end
                        OP_COEF:  cmd.coef_wr = 1'b1;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  ;
                    endcase
                end
            end
            ST_RUN:
            begin
                cmd.mac_issue = 1'b1;
                if (sts.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.pipe_idle) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Hold until the output register can take the result
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_CLEAR;
        end
        else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/stereo_fir_filter_core.sv]
// Filtered frame: history write, then RUN, DRAIN, ROUND, SAT and EMIT in turn before out_valid is raised.
// One MAC per tap per channel, set by the single read port of each history memory.
// Pass-through frame: straight to EMIT; coefficient write: taken in IDLE; clear: a sweep over MAX_TAPS entries.
// Requests: one at a time; next request taken once the current one finishes.
// Reset: control cleared, tap_count = 4096, filter off, then a MAX_TAPS-entry clearing
// pass over both histories with in_stall high (configuration writes still taken).
module stereo_fir_filter_core #(
    parameter int MAX_TAPS    = 4096,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sfir_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sfir_pkg::TAP_COUNT_W-1:0]       cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [sfir_pkg::OP_W-1:0]              op,
    input  logic signed [SAMPLE_BITS-1:0]          left_in,
    input  logic signed [SAMPLE_BITS-1:0]          right_in,
    input  logic [sfir_pkg::TAP_INDEX_W-1:0]       tap_index,
    input  logic signed [COEF_BITS-1:0]            tap_value,
    input  logic                                   frame_last,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [SAMPLE_BITS-1:0]          left_out,
    output logic signed [SAMPLE_BITS-1:0]          right_out,
    output logic                                   clipped,
    output logic                                   last_out
);
    import sfir_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sfir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    sfir_datapath #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .left_in    (left_in),
        .right_in   (right_in),
        .tap_index  (tap_index),
        .tap_value  (tap_value),
        .frame_last (frame_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .left_out   (left_out),
        .right_out  (right_out),
        .clipped    (clipped),
        .last_out   (last_out)
    );

endmodule
